// ===== src/vsms_pkg.sv =====
// Package with payload types, register indexes and unit operation codes for the victim selector.
package vsms_pkg;

	localparam int CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] CFG_CPU_SHIFT = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_AGE_SHIFT = 1'b1;

	localparam logic [4:0] CPU_SHIFT_RESET = 5'd13;
	localparam logic [5:0] AGE_SHIFT_RESET = 6'd20;

	typedef struct packed {
		logic [15:0] task_id;
		logic        has_mm;
		logic        dying;
		logic        swapoff;
		logic [29:0] vm_pages;
		logic [31:0] cpu_ticks;
		logic [47:0] age_ticks;
		logic        niced;
		logic        privileged;
		logic        raw_io;
		logic        last_task;
	} task_in_t;

	typedef struct packed {
		logic        victim_found;
		logic [15:0] victim_id;
		logic [30:0] victim_score;
	} victim_out_t;

	// Operation codes for the shared iterative unit.
	localparam logic [1:0] OP_SQRT = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;

	typedef struct packed {
		logic        start;
		logic [1:0]  op;
		logic [31:0] a;
		logic [31:0] b;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} unit_rsp_t;

endpackage

// ===== src/victim_score_max_select.sv =====
// Top level of the victim selector: sequencer, scan state and output register.
//
//   channel   direction  handshake        payload
//   in        to block   in_valid/in_stall  task_in_t
//   out       from block out_valid/out_stall victim_out_t
//   cfg       to block   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A scored task runs three square roots of 16 steps and two divisions of 32 steps on
// the shared unit, each started by the sequencer and ended by the unit's done pulse,
// between the accept and update states. A division by a zero divisor is skipped
// without starting the unit. Skipped items go straight from the accept state to the
// update state. Reset clears the scan state and restores the shift registers. in_stall
// is high while the sequencer is busy; the last task of a scan also waits in the
// update cycle while the previous result is still stalled in the output register.
module victim_score_max_select
	import vsms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  task_in_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output victim_out_t        out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQC  = 3'd1;
	localparam logic [2:0] ST_DVC  = 3'd2;
	localparam logic [2:0] ST_SQA1 = 3'd3;
	localparam logic [2:0] ST_SQA2 = 3'd4;
	localparam logic [2:0] ST_DVA  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]  state_q;
	logic        wait_q;     // unit started, awaiting done
	logic [4:0]  cpu_shift_q;
	logic [5:0]  age_shift_q;
	task_in_t    item_q;
	logic [31:0] pts_q;
	logic [31:0] cpu_q;
	logic [31:0] age_q;
	logic [30:0] best_score_q;
	logic [15:0] best_id_q;
	logic        best_valid_q;
	logic        locked_q;

	unit_req_t req;
	unit_rsp_t rsp;

	vsms_unit u_unit (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	logic accept;
	logic done_go;
	logic out_load;
	logic [47:0] age_sh;
	logic [31:0] pts_adj;
	logic [30:0] final_pts;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign age_sh    = in_data.age_ticks >> age_shift_q;
	// The update cycle holds only when it must load a result over one still stalled.
	assign done_go   = (state_q == ST_DONE) && !(item_q.last_task && out_valid && out_stall);
	assign out_load  = done_go && item_q.last_task;

	always_comb begin
		pts_adj = item_q.niced ? {pts_q[30:0], 1'b0} : pts_q;
		if (item_q.privileged) pts_adj = pts_adj >> 2;
		if (item_q.raw_io) pts_adj = pts_adj >> 2;
		final_pts = (item_q.has_mm && !item_q.dying) ? pts_adj[30:0] : 31'd0;
	end

	always_comb begin
		req.start = 1'b0;
		req.op = OP_SQRT;
		req.a = cpu_q;
		req.b = rsp.res;
		if (!wait_q) begin
			unique case (state_q)
				ST_SQC:  begin req.start = 1'b1; req.op = OP_SQRT; req.a = cpu_q; end
				ST_DVC, ST_DVA: begin
					req.start = (rsp.res != 32'd0);
					req.op = OP_DIV; req.a = pts_q; req.b = rsp.res;
				end
				ST_SQA1: begin req.start = 1'b1; req.op = OP_SQRT; req.a = age_q; end
				ST_SQA2: begin req.start = 1'b1; req.op = OP_SQRT; req.a = rsp.res; end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q <= 1'b0;
			cpu_shift_q <= CPU_SHIFT_RESET;
			age_shift_q <= AGE_SHIFT_RESET;
			best_score_q <= '0;
			best_id_q <= '0;
			best_valid_q <= 1'b0;
			locked_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_CPU_SHIFT: cpu_shift_q <= cfg_data[4:0];
					CFG_AGE_SHIFT: age_shift_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= (!locked_q && in_data.task_id != 16'd0)
						? ST_SQC : ST_DONE;
				end
				ST_SQC, ST_SQA1, ST_SQA2: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (rsp.done) begin
						wait_q <= 1'b0;
						state_q <= state_q + 3'd1;
					end
				end
				ST_DVC, ST_DVA: begin
					if (!wait_q) begin
						if (rsp.res != 32'd0) wait_q <= 1'b1;
						else state_q <= state_q + 3'd1;
					end else if (rsp.done) begin
						wait_q <= 1'b0;
						state_q <= state_q + 3'd1;
					end
				end
				ST_DONE: begin
					logic        take;
					logic [30:0] bs;
					logic [15:0] bi;
					logic        bv;
					logic        lk;
					take = !locked_q && item_q.task_id != 16'd0;
					bs = best_score_q; bi = best_id_q; bv = best_valid_q; lk = locked_q;
					if (take && (final_pts > bs || item_q.swapoff)) begin
						bs = final_pts; bi = item_q.task_id; bv = 1'b1;
					end
					if (take && item_q.swapoff) lk = 1'b1;
					if (done_go) begin
						if (item_q.last_task) begin
							out_data.victim_found <= bv;
							out_data.victim_id <= bv ? bi : 16'd0;
							out_data.victim_score <= bv ? bs : 31'd0;
							bs = '0; bi = '0; bv = 1'b0; lk = 1'b0;
						end
						best_score_q <= bs; best_id_q <= bi; best_valid_q <= bv;
						locked_q <= lk;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers follow the sequencer without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
			pts_q <= {2'b00, in_data.vm_pages};
			cpu_q <= in_data.cpu_ticks >> cpu_shift_q;
			age_q <= (age_sh[47:32] != 16'd0) ? 32'hFFFF_FFFF : age_sh[31:0];
		end else if ((state_q == ST_DVC || state_q == ST_DVA) && wait_q && rsp.done) begin
			pts_q <= rsp.res;
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.victim_found |-> out_data.victim_id == 16'd0)
		else $error("empty scan with id");
	a_wait_op: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !wait_q) else $error("unit restarted while waiting");

endmodule

// ===== src/vsms_unit.sv =====
// Shared bit-serial unit: integer square root or unsigned division, one bit per cycle.
module vsms_unit
	import vsms_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [1:0]  op_q;
	logic [4:0]  cnt_q;
	logic [31:0] num_q;   // dividend / radicand bits still to bring in
	logic [31:0] den_q;
	logic [33:0] rem_q;
	logic [31:0] quo_q;

	logic [33:0] rem_sh;
	logic [33:0] trial;
	logic        fits;

	always_comb begin
		if (op_q == OP_SQRT) begin
			// Radicand enters two bits per step; trial value is 4*root + 1.
			rem_sh = {rem_q[31:0], num_q[31:30]};
			trial  = {quo_q, 2'b01};
		end else begin
			rem_sh = {rem_q[32:0], num_q[31]};
			trial  = {2'b00, den_q};
		end
		fits = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			num_q <= req.a;
			den_q <= req.b;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= (req.op == OP_SQRT) ? 5'd15 : 5'd31;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - trial : rem_sh;
			quo_q <= {quo_q[30:0], fits};
			num_q <= (op_q == OP_SQRT) ? {num_q[29:0], 2'b00} : {num_q[30:0], 1'b0};
			cnt_q <= cnt_q - 5'd1;
		end
	end

	assign rsp = '{done: done_q, res: quo_q};

endmodule
